// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous active-low reset.
`define SDF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under a synchronous active-low reset.
`define SDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sdf_pkg.sv =====
// Shared types, constants and the playback interval table for the deframer.
// No dependencies; imported by every module of the block.
package sdf_pkg;

  localparam int FRAME_BYTES = 1024;
  localparam int MAX_FRAMES  = 8192;

  localparam int IDX_W    = $clog2(FRAME_BYTES);
  localparam int FRAME_W  = $clog2(MAX_FRAMES);
  localparam int TOTAL_W  = 14;
  localparam int FPS_W    = 6;
  localparam int TMO_W    = 16;
  localparam int OFFSET_W = 23;
  localparam int BYTE_W   = 8;
  localparam int PAGE_W   = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 16;
  localparam int OUT_DATA_W = 56;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hBB;
  localparam int HEADER_BYTES = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FPS          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_PRESENT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_READ    = 1'b1;

  localparam logic [TOTAL_W-1:0] RST_TOTAL   = '0;
  localparam logic [FPS_W-1:0]   RST_FPS     = 6'd30;
  localparam logic [TMO_W-1:0]   RST_TIMEOUT = 16'd2000;

  // floor(1000 / fps), with a rate of zero taken as one
  localparam logic [PAGE_W-1:0] INTERVAL_LUT [64] = '{
    10'd1000, 10'd1000, 10'd500, 10'd333, 10'd250, 10'd200, 10'd166, 10'd142,
    10'd125,  10'd111,  10'd100, 10'd90,  10'd83,  10'd76,  10'd71,  10'd66,
    10'd62,   10'd58,   10'd55,  10'd52,  10'd50,  10'd47,  10'd45,  10'd43,
    10'd41,   10'd40,   10'd38,  10'd37,  10'd35,  10'd34,  10'd33,  10'd32,
    10'd31,   10'd30,   10'd29,  10'd28,  10'd27,  10'd27,  10'd26,  10'd25,
    10'd25,   10'd24,   10'd23,  10'd23,  10'd22,  10'd22,  10'd21,  10'd21,
    10'd20,   10'd20,   10'd20,  10'd19,  10'd19,  10'd18,  10'd18,  10'd18,
    10'd17,   10'd17,   10'd17,  10'd16,  10'd16,  10'd16,  10'd16,  10'd15
  };

  // classified word handed from the front end to the back end
  typedef struct packed {
    logic              is_tick;
    logic              is_sync1;
    logic              is_sync2;
    logic [BYTE_W-1:0] data;
  } sdf_word_t;

  // result word held in the output register
  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   payload;
    logic [IDX_W-1:0]    idx;
    logic                last;
    logic [OFFSET_W-1:0] offset;
    logic [FRAME_W-1:0]  frame;
    logic                streaming;
  } sdf_result_t;

endpackage

// ===== hw/rtl/sdf_front.sv =====
// Front end: accepts input words and classifies them into ticks and sync bytes.
// Depends on sdf_pkg.
module sdf_front import sdf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,   // [0] req_type
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] rx_byte
  input  logic              q_full,
  output logic              q_push,
  output sdf_word_t         q_wdata
);

  logic      fv_r, fv_nxt;
  sdf_word_t fw_r, fw_nxt;
  logic      take;

  assign q_push    = fv_r && !q_full;
  assign in_tready = !fv_r || !q_full;
  assign take      = in_tvalid && in_tready;
  assign q_wdata   = fw_r;

  always_comb begin
    fv_nxt = fv_r;
    fw_nxt = fw_r;
    if (q_push) begin
      fv_nxt = 1'b0;
    end
    if (take) begin
      fv_nxt          = 1'b1;
      fw_nxt.is_tick  = (in_tuser == KIND_TICK);
      fw_nxt.is_sync1 = (in_tdata == SYNC_FIRST);
      fw_nxt.is_sync2 = (in_tdata == SYNC_SECOND);
      fw_nxt.data     = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
    fw_r <= fw_nxt;
  end

endmodule

// ===== hw/rtl/sdf_fifo.sv =====
// Short queue of classified words between the front and back ends.
// Depends on sdf_pkg.
module sdf_fifo import sdf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sdf_word_t         wdata,
  input  logic              pop,
  output sdf_word_t         rdata,
  output logic              not_empty,
  output logic              full,
  output logic [QCNT_W-1:0] count
);

  sdf_word_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign count     = cnt_r;
  assign rdata     = mem_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/sdf_back.sv =====
// Back end: sync hunter, stream ageing, playback timer and output register.
// Depends on sdf_pkg; holds the configuration registers.
module sdf_back import sdf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 q_valid,
  input  sdf_word_t            q_rdata,
  output logic                 q_pop,
  output logic                 out_v,
  input  logic                 out_ready,
  output sdf_result_t          out_res
);

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    HUNT_PAYLOAD
  } hunt_t;

  hunt_t               hunt_r, hunt_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic                strm_r, strm_nxt;
  logic [TMO_W-1:0]    sage_r, sage_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [FRAME_W-1:0]  cur_r, cur_nxt;
  logic                ov_r, ov_nxt;
  sdf_result_t         res_r, res_nxt;

  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [PAGE_W-1:0]   ivl_r, ivl_nxt;
  logic                anim_r, anim_nxt;
  logic [TMO_W-1:0]    tmo_r, tmo_nxt;

  logic [TOTAL_W-1:0]  tot_eff;
  logic [FRAME_W-1:0]  frame_sel;
  logic [TOTAL_W-1:0]  frame_p1;
  logic [TMO_W-1:0]    sage_inc;
  logic [PAGE_W-1:0]   page_inc;
  logic                strm_tick;
  logic                fire;

  assign q_pop   = q_valid && (!ov_r || out_ready);
  assign out_v   = ov_r;
  assign out_res = res_r;

  // tick-side arithmetic, evaluated for the word at the head of the queue
  always_comb begin
    tot_eff   = (total_r > TOTAL_W'(MAX_FRAMES)) ? TOTAL_W'(MAX_FRAMES) : total_r;
    sage_inc  = (sage_r == '1) ? sage_r : sage_r + 1'b1;
    page_inc  = (page_r == '1) ? page_r : page_r + 1'b1;
    strm_tick = strm_r && !(sage_inc > tmo_r);
    fire      = !strm_tick && anim_r && (tot_eff != '0) && (page_inc >= ivl_r);
    frame_sel = ({1'b0, cur_r} < tot_eff) ? cur_r : '0;
    frame_p1  = {1'b0, frame_sel} + 1'b1;
  end

  always_comb begin
    hunt_nxt  = hunt_r;
    cnt_nxt   = cnt_r;
    strm_nxt  = strm_r;
    sage_nxt  = sage_r;
    page_nxt  = page_r;
    cur_nxt   = cur_r;
    ov_nxt    = ov_r;
    res_nxt   = res_r;
    total_nxt = total_r;
    ivl_nxt   = ivl_r;
    anim_nxt  = anim_r;
    tmo_nxt   = tmo_r;

    if (cfg_we) begin
      unique case (cfg_idx)
        REG_TOTAL_FRAMES: total_nxt = cfg_wdata[TOTAL_W-1:0];
        REG_FPS:          ivl_nxt   = INTERVAL_LUT[cfg_wdata[FPS_W-1:0]];
        REG_ANIM_PRESENT: anim_nxt  = cfg_wdata[0];
        REG_TIMEOUT:      tmo_nxt   = cfg_wdata[TMO_W-1:0];
      endcase
    end

    // drop the held result once taken
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    if (q_pop) begin
      if (q_rdata.is_tick) begin
        sage_nxt = sage_inc;
        page_nxt = page_inc;
        strm_nxt = strm_tick;
        if (fire) begin
          page_nxt          = '0;
          cur_nxt           = (frame_p1 >= tot_eff) ? '0 : frame_p1[FRAME_W-1:0];
          ov_nxt            = 1'b1;
          res_nxt.kind      = RES_READ;
          res_nxt.payload   = '0;
          res_nxt.idx       = '0;
          res_nxt.last      = 1'b0;
          res_nxt.offset    = OFFSET_W'({frame_sel, {IDX_W{1'b0}}})
                              + OFFSET_W'(HEADER_BYTES);
          res_nxt.frame     = frame_sel;
          res_nxt.streaming = strm_tick;
        end
      end else begin
        unique case (hunt_r)
          HUNT_PAYLOAD: begin
            ov_nxt          = 1'b1;
            res_nxt.kind    = RES_PAYLOAD;
            res_nxt.payload = q_rdata.data;
            res_nxt.idx     = cnt_r;
            res_nxt.offset  = '0;
            res_nxt.frame   = '0;
            if (cnt_r == IDX_W'(FRAME_BYTES - 1)) begin
              res_nxt.last      = 1'b1;
              res_nxt.streaming = 1'b1;
              strm_nxt          = 1'b1;
              sage_nxt          = '0;
              hunt_nxt          = HUNT_FIRST;
              cnt_nxt           = '0;
            end else begin
              res_nxt.last      = 1'b0;
              res_nxt.streaming = strm_r;
              cnt_nxt           = cnt_r + 1'b1;
            end
          end
          HUNT_SECOND: begin
            // a repeated first sync byte keeps waiting for the second
            if (q_rdata.is_sync2) begin
              hunt_nxt = HUNT_PAYLOAD;
              cnt_nxt  = '0;
            end else if (!q_rdata.is_sync1) begin
              hunt_nxt = HUNT_FIRST;
            end
          end
          default: begin
            hunt_nxt = q_rdata.is_sync1 ? HUNT_SECOND : HUNT_FIRST;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_r  <= HUNT_FIRST;
      cnt_r   <= '0;
      strm_r  <= 1'b0;
      sage_r  <= '0;
      page_r  <= '0;
      cur_r   <= '0;
      ov_r    <= 1'b0;
      total_r <= RST_TOTAL;
      ivl_r   <= INTERVAL_LUT[RST_FPS];
      anim_r  <= 1'b0;
      tmo_r   <= RST_TIMEOUT;
    end else begin
      hunt_r  <= hunt_nxt;
      cnt_r   <= cnt_nxt;
      strm_r  <= strm_nxt;
      sage_r  <= sage_nxt;
      page_r  <= page_nxt;
      cur_r   <= cur_nxt;
      ov_r    <= ov_nxt;
      total_r <= total_nxt;
      ivl_r   <= ivl_nxt;
      anim_r  <= anim_nxt;
      tmo_r   <= tmo_nxt;
    end
    res_r <= res_nxt;
  end

endmodule

// ===== hw/rtl/sync_deframer_with_fallback_player.sv =====
// Top level of the sync-word deframer with fallback animation player.
// Depends on sdf_pkg, sdf_front, sdf_fifo, sdf_back and assert_macros.svh.
//
//   channel | direction | handshake           | contents
//   in_     | slave     | tvalid/tready       | tuser req_type, tdata rx_byte
//   out_    | master    | tvalid/tready/tlast | tuser result_kind, tdata fields
//   cfg_    | write     | cfg_we              | cfg_idx register, cfg_wdata value
//
// One word per clock is sustained while out_tready holds; a word passes the front
// stage register, the 4-deep queue and the output register before out_tvalid rises.
// Throughput is set by the back end, which retires one word a cycle unless stalled.
// Reset is synchronous on rst_n low; config takes its reset values at once.
// A stalled output holds the back end; the queue then fills and in_tready drops.
`include "assert_macros.svh"
module sync_deframer_with_fallback_player import sdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,    // [0] req_type
  input  logic [BYTE_W-1:0]     in_tdata,    // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_tlast,   // frame_last
  output logic                  out_tuser,   // [0] result_kind
  // [7:0] payload_byte, [17:8] byte_index, [40:18] flash_offset,
  // [53:41] frame_number, [54] streaming_now, [55] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  logic [QCNT_W-1:0] q_count;
  sdf_word_t         q_wdata;
  sdf_word_t         q_rdata;
  sdf_result_t       res;

  sdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  sdf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_valid),
    .full      (q_full),
    .count     (q_count)
  );

  sdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_v     (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tuser = res.kind;
  assign out_tlast = res.last;
  assign out_tdata = {1'b0, res.streaming, res.frame, res.offset, res.idx, res.payload};

  `SDF_ASSERT_IMPLY(a_q_bound, clk, rst_n, 1'b1, q_count <= QCNT_W'(QDEPTH),
    "queue count above depth")
  `SDF_ASSERT_IMPLY(a_read_fields, clk, rst_n, out_tvalid && (res.kind == RES_READ),
    (res.payload == '0) && (res.idx == '0) && !res.last
      && (res.offset[IDX_W-1:0] == IDX_W'(HEADER_BYTES)),
    "read request carries payload fields")
  `SDF_ASSERT_IMPLY(a_payload_fields, clk, rst_n,
    out_tvalid && (res.kind == RES_PAYLOAD),
    (res.offset == '0) && (res.frame == '0),
    "payload byte carries read request fields")
  `SDF_ASSERT_IMPLY(a_last_streams, clk, rst_n, out_tvalid && res.last,
    res.streaming && (res.idx == IDX_W'(FRAME_BYTES - 1)),
    "last payload byte without streaming or at wrong index")
  `SDF_ASSERT_NEXT(a_full_stall, clk, rst_n, q_full && !q_pop && q_push, q_full,
    "queue lost an entry while full")

endmodule
